### sv/lru_pkg.sv
// lru_pkg: types, codes and sizes shared by the lru replacement tracker
// depends on nothing
package lru_pkg;
  localparam int ENTRIES = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    CMD_ACCESS = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_EVICT  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] key;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] evicted_key;
    logic [4:0]  occupancy;
    logic [31:0] eviction_count;
  } out_req_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;
endpackage

### sv/lru_ctrl.sv
// lru_ctrl: request sequencing for the tracker
// depends on lru_pkg
module lru_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output lru_pkg::dp_cmd_t dp_cmd
);
  import lru_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall = 1'b1;
    out_valid = 1'b0;
    dp_cmd = '0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### sv/lru_dp.sv
// lru_dp: key store, recency ranks, counters and result register
// depends on lru_pkg
module lru_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lru_pkg::dp_cmd_t   dp_cmd,
  input  lru_pkg::in_req_t   in_data,
  output lru_pkg::out_req_t  out_data
);
  import lru_pkg::*;

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  logic [IDX_W-1:0]    rank_r [ENTRIES];
  logic [CNT_W-1:0]    used_r;
  logic [31:0]         evc_r;
  logic [2:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;
  out_req_t            res_r;

  // lookup on the latched request
  logic [ENTRIES-1:0] hit, lru_hit;
  logic               found, any_free, any_lru;
  logic [IDX_W-1:0]   hit_idx, free_idx, lru_idx;
  logic [IDX_W-1:0]   last_rank;

  assign last_rank = IDX_W'(used_r - CNT_W'(1));

  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    lru_idx = '0;
    any_free = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = valid_r[i] && key_mem[i] == key_r;
      lru_hit[i] = valid_r[i] && rank_r[i] == last_rank;
      if (hit[i]) hit_idx = IDX_W'(i);
      if (lru_hit[i]) lru_idx = IDX_W'(i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
    found = |hit;
    any_lru = |lru_hit;
  end

  logic [IDX_W-1:0] tgt_idx, tgt_rank;
  assign tgt_idx = (cmd_r == CMD_EVICT) ? lru_idx : hit_idx;
  assign tgt_rank = rank_r[tgt_idx];

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r <= in_data.command;
      key_r <= KEY_BITS'(in_data.key);
    end
    if (dp_cmd.exec && cmd_r == CMD_INSERT && !found && any_free &&
        used_r < CNT_W'(ENTRIES))
      key_mem[free_idx] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r <= '0;
      evc_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else if (dp_cmd.exec) begin
      case (cmd_r)
        CMD_ACCESS: begin
          res_r.evicted_key <= '0;
          if (!found) res_r.status <= ST_NOT_FOUND;
          else begin
            res_r.status <= ST_OK;
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && rank_r[i] < tgt_rank) rank_r[i] <= rank_r[i] + 1'b1;
            rank_r[tgt_idx] <= '0;
          end
          res_r.occupancy <= 5'(used_r);
          res_r.eviction_count <= evc_r;
        end
        CMD_INSERT: begin
          res_r.evicted_key <= '0;
          res_r.eviction_count <= evc_r;
          if (found) begin
            res_r.status <= ST_PRESENT;
            res_r.occupancy <= 5'(used_r);
          end else if (used_r >= CNT_W'(ENTRIES) || !any_free) begin
            res_r.status <= ST_FULL;
            res_r.occupancy <= 5'(used_r);
          end else begin
            res_r.status <= ST_OK;
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
            rank_r[free_idx] <= '0;
            valid_r[free_idx] <= 1'b1;
            used_r <= used_r + 1'b1;
            res_r.occupancy <= 5'(used_r + 1'b1);
          end
        end
        CMD_REMOVE, CMD_EVICT: begin
          if ((cmd_r == CMD_REMOVE && !found) || (cmd_r == CMD_EVICT && !any_lru)) begin
            res_r.status <= (cmd_r == CMD_EVICT) ? ST_EMPTY : ST_NOT_FOUND;
            res_r.evicted_key <= '0;
            res_r.occupancy <= 5'(used_r);
            res_r.eviction_count <= evc_r;
          end else begin
            res_r.status <= ST_OK;
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && rank_r[i] > tgt_rank) rank_r[i] <= rank_r[i] - 1'b1;
            rank_r[tgt_idx] <= '0;
            valid_r[tgt_idx] <= 1'b0;
            used_r <= used_r - 1'b1;
            res_r.occupancy <= 5'(used_r - 1'b1);
            if (cmd_r == CMD_EVICT) begin
              res_r.evicted_key <= 32'(key_mem[tgt_idx]);
              evc_r <= evc_r + 32'd1;
              res_r.eviction_count <= evc_r + 32'd1;
            end else begin
              res_r.evicted_key <= '0;
              res_r.eviction_count <= evc_r;
            end
          end
        end
        CMD_CLEAR: begin
          valid_r <= '0;
          for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
          used_r <= '0;
          evc_r <= '0;
          res_r.status <= ST_OK;
          res_r.evicted_key <= '0;
          res_r.occupancy <= '0;
          res_r.eviction_count <= '0;
        end
        default: begin
          res_r.status <= ST_OK;
          res_r.evicted_key <= '0;
          res_r.occupancy <= 5'(used_r);
          res_r.eviction_count <= evc_r;
        end
      endcase
    end
  end

  assign out_data = res_r;
endmodule

### sv/lru_replacement_tracker_core.sv
// lru_replacement_tracker_core: top level of the lru replacement tracker
// depends on lru_pkg, lru_ctrl, lru_dp
//
// usage: one request carries a command and a key tag; each request gives
// exactly one result with status, evicted key, occupancy and the eviction
// count. in_valid/in_stall take a request when valid is high and stall low;
// out_valid/out_stall return the result the same way.
// order: a taken request is latched, the tracker is updated and the result
// registered, then the result is held with out_valid until taken; a new
// request is taken only in idle after that, as the rank update for a
// request needs the lookup of the stored keys first.
// reset (rst_n low, synchronous) empties the tracker, clears all ranks and
// zeroes occupancy and eviction count; no clearing pass is needed.
// while out_stall is high the result holds and no new request is taken.
module lru_replacement_tracker_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lru_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lru_pkg::out_req_t out_data
);
  import lru_pkg::*;

  dp_cmd_t dp_cmd;

  lru_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .dp_cmd(dp_cmd)
  );

  lru_dp u_dp (
    .clk(clk), .rst_n(rst_n), .dp_cmd(dp_cmd), .in_data(in_data),
    .out_data(out_data)
  );
endmodule

### sv/lru_checker.sv
// lru_checker: port level checks for the tracker, bound to the top level
// depends on lru_pkg
module lru_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input lru_pkg::out_req_t out_data
);
  import lru_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // a taken request is followed by its result, after the latch and update steps
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("result missing");

  // no request taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken with result pending");

  // occupancy never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.occupancy <= 5'(ENTRIES))
    else $error("occupancy over capacity");

  // evicted key is zero on any failed request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.evicted_key == '0)
    else $error("evicted key on failed request");
endmodule

bind lru_replacement_tracker_core lru_checker u_lru_checker (.*);
